// ===== rtl/ffca_pkg.sv =====
// Shared types and constants for the first-fit coalescing allocator.
`default_nettype none
package ffca_pkg;
    localparam int DEF_ARENA_BYTES  = 4096;
    localparam int DEF_HEADER_BYTES = 16;

    localparam logic       ACT_ALLOC = 1'b0;
    localparam logic       ACT_FREE  = 1'b1;
    localparam logic [1:0] ST_ALLOC  = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_FREED  = 2'd2;

    typedef struct packed {
        logic        action;
        logic [11:0] request_size;
        logic [11:0] block_offset;
        logic        ptr_is_null;
    } t_req;

    typedef struct packed {
        logic [11:0] result_offset;
        logic [1:0]  status;
    } t_rsp;
endpackage
`default_nettype wire

// ===== rtl/first_fit_coalescing_allocator.sv =====
// Top level: first-fit free-list allocator with coalescing over a header memory.
//
// Usage:
//   Request channel: drive i_req and raise start; the request is taken at a
//   rising edge with start high and busy low. One request is in work at a time.
//   Result channel: o_strobe is high for exactly one cycle with o_rsp. There
//   is no back pressure; the receiver must take the result in that cycle.
//   Allocate returns the user-area offset (status 0) or status 1 when no free
//   block fits. Free always returns status 2 with offset 0.
// Sequence:
//   Allocate: walks the free list, plus a write step (S_WR2) when a block is
//   split. Free: reads the freed header (S_FSZ), walks the entries below it
//   (S_FWALK), checks (S_FCHK) and updates the lower free block (S_WR2)
//   when one exists and the free is applied. Null or out-of-arena frees answer
//   from idle. The walk is bound by the single read port of the header memory:
//   one header per cycle, up to ARENA_BYTES/HEADER_BYTES headers per request.
// Reset:
//   After reset a clearing pass writes every header entry, one per cycle, and
//   busy stays high during it. Afterwards one free block spans the whole
//   arena.
`default_nettype none
module first_fit_coalescing_allocator
    import ffca_pkg::*;
#(
    parameter int ARENA_BYTES  = DEF_ARENA_BYTES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_strobe,
    output t_rsp      o_rsp
);
    localparam int AW = $clog2(ARENA_BYTES);
    localparam int LW = AW + 1;               // link holds NIL = ARENA_BYTES
    localparam int SW = AW;                   // sizes stay below the arena
    localparam int CW = ((AW > 12) ? AW : 12) + 2;
    localparam int EW = LW + SW;
    localparam logic [LW-1:0] NIL  = LW'(ARENA_BYTES);
    localparam logic [CW-1:0] HDR  = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] AREN = CW'(ARENA_BYTES);
    localparam logic [SW-1:0] INIT_SIZE = SW'(ARENA_BYTES - HEADER_BYTES);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_AWALK = 8'b0000_0100,
        S_WR2   = 8'b0000_1000,
        S_FSZ   = 8'b0001_0000,
        S_FWALK = 8'b0010_0000,
        S_FCHK  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // header memory: {link, size}
    logic [EW-1:0] r_mem [ARENA_BYTES];
    logic [EW-1:0] r_rdata;

    t_state        r_state, n_state;
    logic [LW-1:0] r_head, n_head;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_prev, n_prev;
    logic [SW-1:0] r_prev_size, n_prev_size;
    logic [AW-1:0] r_h, n_h;
    logic [SW-1:0] r_sz, n_sz;
    logic [11:0]   r_reqsz, n_reqsz;
    logic [AW-1:0] r_w2_addr, n_w2_addr;
    logic [EW-1:0] r_w2_data, n_w2_data;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_strobe, n_strobe;
    t_rsp          r_rsp, n_rsp;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] wr_data;

    logic [LW-1:0] rd_link;
    logic [SW-1:0] rd_size;
    assign rd_link = r_rdata[EW-1:SW];
    assign rd_size = r_rdata[SW-1:0];

    // scratch values
    logic [CW-1:0] c_bs, c_req, c_t, c_lim, c_sz, c_hend, c_pend, c_hs;
    logic [LW-1:0] c_hl;
    logic [CW-1:0] c_off;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_prev_size = r_prev_size;
        n_h         = r_h;
        n_sz        = r_sz;
        n_reqsz     = r_reqsz;
        n_w2_addr   = r_w2_addr;
        n_w2_data   = r_w2_data;
        n_clr       = r_clr;
        n_strobe    = 1'b0;
        n_rsp       = r_rsp;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        c_bs   = CW'(rd_size);
        c_req  = CW'(r_reqsz);
        c_t    = CW'(r_cur) + c_bs - c_req;
        c_off  = CW'(i_req.block_offset);
        c_lim  = AREN - HDR - CW'(r_h);
        c_sz   = (c_bs > c_lim) ? c_lim : c_bs;
        c_hend = CW'(r_h) + HDR + CW'(r_sz);
        c_pend = CW'(r_prev) + HDR + CW'(r_prev_size);
        c_hs   = CW'(r_sz);
        c_hl   = r_cur;

        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = {NIL, (r_clr == '0) ? INIT_SIZE : SW'(0)};
                n_clr   = r_clr + 1'b1;
                if (r_clr == AW'(ARENA_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_req.action == ACT_ALLOC) begin
                        n_reqsz = i_req.request_size;
                        n_cur   = r_head;
                        n_prev  = NIL;
                        if (r_head == NIL) begin
                            n_strobe = 1'b1;
                            n_rsp    = '{result_offset: '0, status: ST_NOFIT};
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head[AW-1:0];
                            n_state = S_AWALK;
                        end
                    end else if (i_req.ptr_is_null || c_off < HDR || c_off > AREN) begin
                        n_strobe = 1'b1;
                        n_rsp    = '{result_offset: '0, status: ST_FREED};
                    end else begin
                        n_h     = AW'(c_off - HDR);
                        rd_en   = 1'b1;
                        rd_addr = AW'(c_off - HDR);
                        n_state = S_FSZ;
                    end
                end
            end
            S_AWALK: begin
                if (c_bs >= c_req) begin
                    n_state = S_DONE;
                    if (c_bs > c_req + HDR) begin
                        // carve the request off the top end of the block
                        wr_en     = 1'b1;
                        wr_addr   = r_cur[AW-1:0];
                        wr_data   = {rd_link, SW'(c_bs - c_req - HDR)};
                        n_w2_addr = c_t[AW-1:0];
                        n_w2_data = {NIL, SW'(r_reqsz)};
                        n_rsp     = '{result_offset: 12'(c_t + HDR), status: ST_ALLOC};
                        n_state   = S_WR2;
                    end else begin
                        // whole block leaves the list
                        if (r_prev != NIL) begin
                            wr_en   = 1'b1;
                            wr_addr = r_prev[AW-1:0];
                            wr_data = {rd_link, r_prev_size};
                        end else begin
                            n_head = rd_link;
                        end
                        n_rsp    = '{result_offset: 12'(CW'(r_cur) + HDR), status: ST_ALLOC};
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_prev      = r_cur;
                    n_prev_size = rd_size;
                    n_cur       = rd_link;
                    if (rd_link == NIL) begin
                        n_strobe = 1'b1;
                        n_rsp    = '{result_offset: '0, status: ST_NOFIT};
                        n_state  = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = rd_link[AW-1:0];
                    end
                end
            end
            S_WR2: begin
                wr_en    = 1'b1;
                wr_addr  = r_w2_addr;
                wr_data  = r_w2_data;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_FSZ: begin
                n_sz   = SW'(c_sz);
                n_prev = NIL;
                n_cur  = r_head;
                rd_addr = r_head[AW-1:0];
                rd_en   = (r_head != NIL);
                if (r_head != NIL && r_head < LW'(r_h)) begin
                    n_state = S_FWALK;
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_FWALK: begin
                n_prev      = r_cur;
                n_prev_size = rd_size;
                n_cur       = rd_link;
                rd_addr     = rd_link[AW-1:0];
                rd_en       = (rd_link != NIL);
                if (!(rd_link != NIL && rd_link < LW'(r_h))) begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                n_rsp    = '{result_offset: '0, status: ST_FREED};
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if ((r_cur != NIL && c_hend > CW'(r_cur)) ||
                    (r_prev != NIL && c_pend > CW'(r_h))) begin
                    // overlaps a free block: ignore
                end else begin
                    if (r_cur != NIL && c_hend == CW'(r_cur)) begin
                        c_hs = CW'(r_sz) + HDR + c_bs;
                        c_hl = rd_link;
                    end
                    wr_en   = 1'b1;
                    wr_addr = r_h;
                    wr_data = {c_hl, SW'(c_hs)};
                    if (r_prev != NIL) begin
                        n_w2_addr = r_prev[AW-1:0];
                        if (c_pend == CW'(r_h)) begin
                            n_w2_data = {c_hl, SW'(CW'(r_prev_size) + HDR + c_hs)};
                        end else begin
                            n_w2_data = {LW'(r_h), r_prev_size};
                        end
                        n_strobe = 1'b0;
                        n_state  = S_WR2;
                    end else begin
                        n_head = LW'(r_h);
                    end
                end
            end
            S_DONE: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_head   <= '0;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_clr    <= n_clr;
            r_strobe <= n_strobe;
        end
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_prev_size <= n_prev_size;
        r_h         <= n_h;
        r_sz        <= n_sz;
        r_reqsz     <= n_reqsz;
        r_w2_addr   <= n_w2_addr;
        r_w2_data   <= n_w2_data;
        r_rsp       <= n_rsp;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;
endmodule
`default_nettype wire
